>>> hw/rtl/bootloader_packet_receiver_top_macros.svh
// Assertion macros for the bind checker file.
`ifndef BOOTLOADER_PACKET_RECEIVER_TOP_MACROS_SVH
`define BOOTLOADER_PACKET_RECEIVER_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BPRX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define BPRX_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/bprx_pkg.sv
`timescale 1ns / 1ps
package bprx_pkg;

  localparam int PAYLOAD_LEN = 64;
  localparam int HDR_LEN   = 7;
  localparam int PAD_LEN   = 7;
  localparam int PKT_LEN   = HDR_LEN + PAYLOAD_LEN + PAD_LEN + 2;
  localparam int CRC_END   = PKT_LEN - 2;

  localparam int CNT_W  = $clog2(PKT_LEN + 1);
  localparam int IDX_W  = $clog2(PAYLOAD_LEN);
  localparam int HIDX_W = $clog2(HDR_LEN);

  // Framing characters
  localparam logic [7:0] CH_STX   = 8'h02;
  localparam logic [7:0] CH_ETX   = 8'h03;
  localparam logic [7:0] CH_SUBST = 8'h04;
  localparam logic [7:0] PKT_TYPE = 8'hFF;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Commands
  localparam logic [7:0] CMD_QUERY  = 8'h00;
  localparam logic [7:0] CMD_CHECK  = 8'h08;
  localparam logic [7:0] CMD_WREN   = 8'h10;
  localparam logic [7:0] CMD_FLASH  = 8'h40;
  localparam logic [7:0] CMD_EEPROM = 8'hA5;
  localparam logic [7:0] CMD_EXEC   = 8'h55;
  localparam logic [7:0] CMD_RESET  = 8'hAA;

  // Verdicts
  localparam logic [2:0] VD_IGNORE = 3'd0;
  localparam logic [2:0] VD_ACK    = 3'd1;
  localparam logic [2:0] VD_NAK    = 3'd2;
  localparam logic [2:0] VD_QUERY  = 3'd3;
  localparam logic [2:0] VD_APPBAD = 3'd4;
  localparam logic [2:0] VD_EXEC   = 3'd5;
  localparam logic [2:0] VD_RESET  = 3'd6;

  // Write targets
  localparam logic [1:0] TGT_NONE   = 2'd0;
  localparam logic [1:0] TGT_FLASH  = 2'd1;
  localparam logic [1:0] TGT_EEPROM = 2'd2;

  // Configuration register indexes
  localparam logic [7:0] REG_NODE_ADDR = 8'd0;
  localparam logic [7:0] REG_APP_START = 8'd1;

  // Result beat layout in m_tdata, lowest bit up
  localparam int OUT_BITS = 3 + 8 + 16 + 2 + IDX_W + 8;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic [IDX_W-1:0] byte_index;
    logic [1:0]       write_target;
    logic [15:0]      param_value;
    logic [7:0]       command;
    logic [2:0]       verdict;
  } result_t;

endpackage

>>> hw/rtl/bootloader_packet_receiver_top.sv
`timescale 1ns / 1ps
// Bootloader packet receiver. Raw link bytes enter on the s_ stream one beat at a
// time; bytes before STX are skipped, SUBST escapes the next byte and ETX closes the
// packet. A byte that falls under the CRC is accepted and then run through the
// bit-serial CRC-16 shifter, which handles one polynomial bit per cycle; s_tready
// is low meanwhile. Other bytes are taken without a stall. ETX moves to a finish
// state (held there while an earlier result beat still waits in the output
// register), which loads the single result beat, or is followed by 64 beats, one
// per payload byte (one per cycle, paced by m_tready and the registered payload
// memory read), for an accepted flash or EEPROM write. No input is taken until
// the last beat is loaded into the output register.
// The payload memory has no clearing pass; it is read only after a full packet.
module bootloader_packet_receiver_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // rx_byte[7:0]
  input  logic                        s_tuser,   // app_check_good
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // verdict[2:0], command[10:3], param_value[26:11], write_target[28:27],
  // byte_index[34:29], data_byte[42:35], zero fill above
  output logic [bprx_pkg::OUT_W-1:0]  m_tdata,
  output logic                        m_tlast,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [7:0]                  cfg_index,
  input  logic [15:0]                 cfg_data
);

  // Sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CRC    = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;
  localparam logic [1:0] ST_DRAIN  = 2'd3;

  // Framing modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_DATA = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;

  localparam int CNT_W = bprx_pkg::CNT_W;
  localparam int IDX_W = bprx_pkg::IDX_W;

  logic [1:0]        state;
  logic [1:0]        frame_mode;
  logic [2:0]        bit_cnt;
  logic [CNT_W-1:0]  byte_count;
  logic [15:0]       running_crc;
  logic [7:0]        hdr [0:bprx_pkg::HDR_LEN-1];
  logic [15:0]       received_crc;
  logic [15:0]       expected_seq;
  logic              writes_enabled;
  logic              app_good;
  logic [7:0]        node_address;
  logic [15:0]       app_start_word;

  logic [7:0]        payload_mem [0:bprx_pkg::PAYLOAD_LEN-1];
  logic [7:0]        mem_q;
  logic [IDX_W-1:0]  rd_ptr;
  logic [IDX_W-1:0]  rd_ptr_next;

  bprx_pkg::result_t res;
  logic              res_last;

  logic              in_beat;
  logic              out_free;
  logic              store_en;
  logic [7:0]        rx_b;
  logic [CNT_W-1:0]  pay_off;
  logic              drain_ld;

  // Finish decision
  logic [7:0]        fin_cmd;
  logic [15:0]       fin_param;
  logic [15:0]       fin_seq;
  logic [2:0]        fin_verdict;
  logic [1:0]        fin_tgt;
  logic              fin_bad;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_beat   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign rx_b      = s_tdata;
  assign drain_ld  = (state == ST_DRAIN) && out_free;
  assign pay_off   = byte_count - CNT_W'(bprx_pkg::HDR_LEN);

  assign m_tdata = {{(bprx_pkg::OUT_W - bprx_pkg::OUT_BITS){1'b0}}, res};
  assign m_tlast = res_last;

  // A byte is stored when it is data inside a packet (escaped, or not ETX/SUBST).
  always_comb begin
    store_en = 1'b0;
    if (in_beat) begin
      if (frame_mode == MODE_ESC) begin
        store_en = 1'b1;
      end else if (frame_mode == MODE_DATA) begin
        store_en = (rx_b != bprx_pkg::CH_ETX) && (rx_b != bprx_pkg::CH_SUBST);
      end
    end
  end

  // Judge the closed packet from the header, the CRCs and the session state.
  always_comb begin
    fin_cmd     = hdr[2];
    fin_param   = {hdr[4], hdr[3]};
    fin_seq     = {hdr[6], hdr[5]};
    fin_verdict = bprx_pkg::VD_ACK;
    fin_tgt     = bprx_pkg::TGT_NONE;
    fin_bad     = (byte_count < CNT_W'(bprx_pkg::PKT_LEN)) ||
                  (running_crc != received_crc) ||
                  (hdr[0] != bprx_pkg::PKT_TYPE) ||
                  (hdr[1] != node_address);
    case (fin_cmd)
      bprx_pkg::CMD_QUERY:  fin_verdict = bprx_pkg::VD_QUERY;
      bprx_pkg::CMD_WREN:   fin_verdict = bprx_pkg::VD_ACK;
      bprx_pkg::CMD_FLASH: begin
        if (writes_enabled && (fin_seq == expected_seq) && (fin_param >= app_start_word))
          fin_tgt = bprx_pkg::TGT_FLASH;
        else
          fin_verdict = bprx_pkg::VD_NAK;
      end
      bprx_pkg::CMD_EEPROM: begin
        if (writes_enabled && (fin_seq == expected_seq)) begin
          fin_tgt   = bprx_pkg::TGT_EEPROM;
          fin_param = {8'h00, hdr[3]};
        end else begin
          fin_verdict = bprx_pkg::VD_NAK;
        end
      end
      bprx_pkg::CMD_CHECK:  fin_verdict = app_good ? bprx_pkg::VD_ACK : bprx_pkg::VD_APPBAD;
      bprx_pkg::CMD_EXEC:   fin_verdict = bprx_pkg::VD_EXEC;
      bprx_pkg::CMD_RESET:  fin_verdict = bprx_pkg::VD_RESET;
      default:              fin_verdict = bprx_pkg::VD_NAK;
    endcase
    if (fin_bad) begin
      fin_cmd     = 8'h00;
      fin_param   = 16'h0000;
      fin_verdict = bprx_pkg::VD_IGNORE;
      fin_tgt     = bprx_pkg::TGT_NONE;
    end
  end

  // Read pointer: restart at the finish cycle, advance on every drain beat so the
  // registered read already holds the next byte.
  always_comb begin
    rd_ptr_next = rd_ptr;
    if (state == ST_FINISH) begin
      rd_ptr_next = '0;
    end else if (drain_ld) begin
      rd_ptr_next = rd_ptr + IDX_W'(1);
    end
  end

  // Payload memory: write while receiving, registered read during the drain.
  always_ff @(posedge clk) begin
    if (store_en && (byte_count >= CNT_W'(bprx_pkg::HDR_LEN)) &&
        (byte_count < CNT_W'(bprx_pkg::HDR_LEN + bprx_pkg::PAYLOAD_LEN))) begin
      payload_mem[pay_off[IDX_W-1:0]] <= rx_b;
    end
    mem_q <= payload_mem[rd_ptr_next];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_address   <= 8'd31;
      app_start_word <= 16'd2048;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bprx_pkg::REG_NODE_ADDR: node_address   <= cfg_data[7:0];
        bprx_pkg::REG_APP_START: app_start_word <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, framing, CRC shifter and session state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      frame_mode     <= MODE_IDLE;
      bit_cnt        <= '0;
      byte_count     <= '0;
      running_crc    <= '0;
      received_crc   <= '0;
      expected_seq   <= '0;
      writes_enabled <= 1'b0;
      app_good       <= 1'b0;
      rd_ptr         <= '0;
      for (int i = 0; i < bprx_pkg::HDR_LEN; i++) hdr[i] <= '0;
    end else begin
      rd_ptr <= rd_ptr_next;
      unique case (state)
        ST_IDLE: begin
          if (in_beat) begin
            unique case (frame_mode)
              MODE_ESC: frame_mode <= MODE_DATA;
              MODE_DATA: begin
                if (rx_b == bprx_pkg::CH_ETX) begin
                  // close the packet; sample the app check with the ETX beat
                  frame_mode <= MODE_IDLE;
                  app_good   <= s_tuser;
                  state      <= ST_FINISH;
                end else if (rx_b == bprx_pkg::CH_SUBST) begin
                  frame_mode <= MODE_ESC;
                end
              end
              default: begin
                if (rx_b == bprx_pkg::CH_STX) begin
                  frame_mode  <= MODE_DATA;
                  byte_count  <= '0;
                  running_crc <= '0;
                end
              end
            endcase
            if (store_en && (byte_count < CNT_W'(bprx_pkg::PKT_LEN))) begin
              byte_count <= byte_count + CNT_W'(1);
              if (byte_count < CNT_W'(bprx_pkg::CRC_END)) begin
                // fold the byte into the top and shift it out bit by bit
                running_crc <= running_crc ^ {rx_b, 8'h00};
                bit_cnt     <= '0;
                state       <= ST_CRC;
              end
              if (byte_count < CNT_W'(bprx_pkg::HDR_LEN)) begin
                hdr[byte_count[bprx_pkg::HIDX_W-1:0]] <= rx_b;
              end
              if (byte_count == CNT_W'(bprx_pkg::CRC_END)) begin
                received_crc[7:0] <= rx_b;
              end
              if (byte_count == CNT_W'(bprx_pkg::CRC_END + 1)) begin
                received_crc[15:8] <= rx_b;
              end
            end
          end
        end
        ST_CRC: begin
          running_crc <= {running_crc[14:0], 1'b0} ^
                         (running_crc[15] ? bprx_pkg::CRC_POLY : 16'h0000);
          bit_cnt     <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) state <= ST_IDLE;
        end
        ST_FINISH: begin
          if (out_free) begin
            if (!fin_bad) begin
              if (fin_cmd == bprx_pkg::CMD_QUERY) begin
                expected_seq   <= '0;
                writes_enabled <= 1'b0;
              end else if (fin_verdict == bprx_pkg::VD_ACK) begin
                expected_seq <= expected_seq + 16'd1;
              end
              if (fin_cmd == bprx_pkg::CMD_WREN) writes_enabled <= 1'b1;
            end
            state <= (fin_tgt == bprx_pkg::TGT_NONE) ? ST_IDLE : ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (drain_ld && (rd_ptr == IDX_W'(bprx_pkg::PAYLOAD_LEN - 1))) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register: hold a beat until taken, load the verdict or the next payload byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if ((state == ST_FINISH) && out_free) begin
        res.verdict      <= fin_verdict;
        res.command      <= fin_cmd;
        res.param_value  <= fin_param;
        res.write_target <= fin_tgt;
        res.byte_index   <= '0;
        res.data_byte    <= 8'h00;
        res_last         <= 1'b1;
        // a write streams its beats from the drain state instead
        m_tvalid         <= (fin_tgt == bprx_pkg::TGT_NONE);
      end else if (drain_ld) begin
        res.byte_index <= rd_ptr;
        res.data_byte  <= mem_q;
        res_last       <= (rd_ptr == IDX_W'(bprx_pkg::PAYLOAD_LEN - 1));
        m_tvalid       <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/bprx_checker.sv
`timescale 1ns / 1ps
`include "bootloader_packet_receiver_top_macros.svh"
module bprx_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [bprx_pkg::OUT_W-1:0] m_tdata,
  input logic                       m_tlast
);

  logic [2:0] vd;
  logic [1:0] tgt;

  assign vd  = m_tdata[2:0];
  assign tgt = m_tdata[28:27];

  // hold a stalled beat
  `BPRX_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result beat changed")
  // a beat without a write target is the only beat of its packet
  `BPRX_ASSERT(a_single_last, m_tvalid && (tgt == bprx_pkg::TGT_NONE) |-> m_tlast, "single result not marked last")
  // an ignored packet carries no command or param
  `BPRX_ASSERT(a_ignore_clean, m_tvalid && (vd == bprx_pkg::VD_IGNORE) |-> (m_tdata[26:3] == 24'h0), "ignore verdict with fields set")
  // input stays blocked while a payload burst is mid-stream
  `BPRX_ASSERT(a_drain_block, m_tvalid && !m_tlast |-> !s_tready, "input taken during payload burst")
  // nothing comes out right after reset
  `BPRX_ASSERT_ALWAYS(a_reset_idle, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind bootloader_packet_receiver_top bprx_checker u_bprx_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

>>> sim/bootloader_packet_receiver_checker.sv
`timescale 1ns / 1ps
// Watches the link, result and register channels, predicts the result beats of
// every packet and compares them in order.
module bootloader_packet_receiver_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [7:0]                 s_tdata,
  input  logic                       s_tuser,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [bprx_pkg::OUT_W-1:0] m_tdata,
  input  logic                       m_tlast,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [7:0]                 cfg_index,
  input  logic [15:0]                cfg_data,
  output int                         errors,
  output int                         pending,
  output logic [15:0]                seq_hint
);
  import bprx_pkg::*;

  localparam int RESULT_BITS = $bits(result_t);

  typedef enum logic [1:0] {FRAME_IDLE, FRAME_BODY, FRAME_ESCAPE} frame_e;

  typedef struct packed {
    logic    last;
    result_t f;
  } beat_t;

  frame_e      frame;
  int          stored;
  logic [15:0] crc_acc;
  logic [15:0] crc_rx;
  logic [7:0]  hdr [HDR_LEN];
  logic [7:0]  row [PAYLOAD_LEN];
  logic [15:0] seq_want;
  logic        wr_en;
  logic [7:0]  addr_reg;
  logic [15:0] app_start_reg;
  beat_t       pending_results [$];
  int          beat_no;

  function automatic logic [15:0] crc_ccitt_next(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  task automatic report(input string msg);
    $display("[%0t] result beat %0d: %s", $time, beat_no, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // Store one unescaped packet byte; anything past the packet length is dropped.
  task automatic store_packet_byte(input logic [7:0] b);
    if (stored >= PKT_LEN) return;
    if (stored < CRC_END) crc_acc = crc_ccitt_next(crc_acc, b);
    if (stored < HDR_LEN) hdr[stored] = b;
    else if (stored < HDR_LEN + PAYLOAD_LEN) row[stored - HDR_LEN] = b;
    else if (stored == CRC_END) crc_rx[7:0] = b;
    else if (stored == CRC_END + 1) crc_rx[15:8] = b;
    stored++;
  endtask

  // Decide the verdict at ETX and queue the beats it produces.
  task automatic judge_packet(input logic good);
    logic [7:0]  cmd;
    logic [15:0] param;
    logic [15:0] seq;
    logic [2:0]  vd;
    logic [1:0]  tgt;
    beat_t       e;
    e = '0;
    e.last = 1'b1;
    if (stored < PKT_LEN || crc_acc != crc_rx || hdr[0] != PKT_TYPE ||
        hdr[1] != addr_reg) begin
      pending_results.push_back(e);
      return;
    end
    cmd   = hdr[2];
    param = {hdr[4], hdr[3]};
    seq   = {hdr[6], hdr[5]};
    vd    = VD_ACK;
    tgt   = TGT_NONE;
    case (cmd)
      CMD_QUERY: begin
        seq_want = '0;
        wr_en    = 1'b0;
        vd       = VD_QUERY;
      end
      CMD_WREN: wr_en = 1'b1;
      CMD_FLASH: begin
        if (wr_en && seq == seq_want && param >= app_start_reg) tgt = TGT_FLASH;
        else vd = VD_NAK;
      end
      CMD_EEPROM: begin
        if (wr_en && seq == seq_want) begin
          tgt   = TGT_EEPROM;
          param = {8'h00, param[7:0]};
        end else begin
          vd = VD_NAK;
        end
      end
      CMD_CHECK: vd = good ? VD_ACK : VD_APPBAD;
      CMD_EXEC:  vd = VD_EXEC;
      CMD_RESET: vd = VD_RESET;
      default:   vd = VD_NAK;
    endcase
    if (vd == VD_ACK) seq_want = seq_want + 16'd1;
    e.f.verdict      = vd;
    e.f.command      = cmd;
    e.f.param_value  = param;
    e.f.write_target = tgt;
    if (tgt == TGT_NONE) begin
      pending_results.push_back(e);
    end else begin
      for (int i = 0; i < PAYLOAD_LEN; i++) begin
        e.f.byte_index = i[IDX_W-1:0];
        e.f.data_byte  = row[i];
        e.last         = (i == PAYLOAD_LEN - 1);
        pending_results.push_back(e);
      end
    end
  endtask

  task automatic decode_link_byte(input logic [7:0] b, input logic good);
    case (frame)
      FRAME_ESCAPE: begin
        store_packet_byte(b);
        frame = FRAME_BODY;
      end
      FRAME_BODY: begin
        if (b == CH_ETX) begin
          frame = FRAME_IDLE;
          judge_packet(good);
        end else if (b == CH_SUBST) begin
          frame = FRAME_ESCAPE;
        end else begin
          store_packet_byte(b);
        end
      end
      default: begin
        if (b == CH_STX) begin
          frame   = FRAME_BODY;
          stored  = 0;
          crc_acc = '0;
        end
      end
    endcase
  endtask

  task automatic compare_result;
    result_t got;
    beat_t   want;
    got = m_tdata[RESULT_BITS-1:0];
    if (pending_results.size() == 0) begin
      report("arrived with no result expected");
    end else begin
      want = pending_results.pop_front();
      check_field("verdict", got.verdict, want.f.verdict);
      check_field("command", got.command, want.f.command);
      check_field("param_value", got.param_value, want.f.param_value);
      check_field("write_target", got.write_target, want.f.write_target);
      check_field("byte_index", got.byte_index, want.f.byte_index);
      check_field("data_byte", got.data_byte, want.f.data_byte);
      check_field("last", m_tlast, want.last);
    end
    beat_no++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      errors        = 0;
      beat_no       = 0;
      frame         = FRAME_IDLE;
      stored        = 0;
      crc_acc       = '0;
      crc_rx        = '0;
      seq_want      = '0;
      wr_en         = 1'b0;
      addr_reg      = 8'd31;
      app_start_reg = 16'd2048;
      foreach (hdr[i]) hdr[i] = '0;
      foreach (row[i]) row[i] = '0;
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NODE_ADDR: addr_reg = cfg_data[7:0];
          REG_APP_START: app_start_reg = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) decode_link_byte(s_tdata, s_tuser);
      if (m_tvalid && m_tready) compare_result();
    end
    pending  <= pending_results.size();
    seq_hint <= seq_want;
  end

endmodule

>>> sim/bootloader_packet_receiver_top_tb.sv
`timescale 1ns / 1ps
module bootloader_packet_receiver_top_tb;
  import bprx_pkg::*;

  // Longest legal stretch without any beat: the forced output hold plus slack.
  localparam int WATCHDOG_LIMIT = 4000;
  // Output side stops taking beats this long once, to back the block up.
  localparam int HOLD_CYCLES    = 600;
  // Cycles to let a byte still in the CRC shifter drain before a register write.
  localparam int SETTLE_CYCLES  = 24;

  typedef enum {FAULT_NONE, FAULT_CRC, FAULT_TYPE, FAULT_ADDR, FAULT_SHORT,
                FAULT_LONG, FAULT_OPEN} fault_e;
  typedef enum {FILL_RANDOM, FILL_EXTREME, FILL_FRAMING} fill_e;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [7:0]        s_tdata;
  logic              s_tuser;
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_W-1:0]  m_tdata;
  logic              m_tlast;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [7:0]        cfg_index;
  logic [15:0]       cfg_data;

  int                chk_errors;
  int                chk_pending;
  logic [15:0]       seq_hint;

  // Register values as the stimulus knows them, used to build packets that pass
  logic [7:0]        cur_addr;
  logic [15:0]       cur_app_start;
  bit                calm;
  int                out_beats;
  int                idle_cycles;

  bootloader_packet_receiver_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bootloader_packet_receiver_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (chk_errors),
    .pending   (chk_pending),
    .seq_hint  (seq_hint)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Mostly no gap, some short ones, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] crc_ccitt(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  // Offer one link byte, with an optional gap in front; return once the beat is taken.
  task automatic send_link_byte(input logic [7:0] b, input logic good);
    int gap;
    gap = calm ? 0 : pick_gap();
    repeat (gap) @(negedge clk) s_tvalid <= 1'b0;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= good;
    do @(posedge clk); while (!s_tready);
  endtask

  // Build a packet, stuff it and send it framed by STX/ETX.
  // seq_off = 0 gives the sequence number the block currently waits for.
  task automatic send_packet(input logic [7:0] cmd, input logic [15:0] param,
                             input int seq_off, input fill_e fill,
                             input fault_e fault, input logic good);
    logic [7:0]  body [$];
    logic [7:0]  b;
    logic [15:0] seq;
    logic [15:0] crc;
    int          n;
    // Drop valid at the frame boundary; the sequence hint has settled by now.
    @(negedge clk) s_tvalid <= 1'b0;
    seq = seq_hint + seq_off[15:0];
    body.push_back((fault == FAULT_TYPE) ? 8'($urandom_range(0, 254)) : PKT_TYPE);
    body.push_back((fault == FAULT_ADDR) ? cur_addr ^ 8'($urandom_range(1, 255))
                                         : cur_addr);
    body.push_back(cmd);
    body.push_back(param[7:0]);
    body.push_back(param[15:8]);
    body.push_back(seq[7:0]);
    body.push_back(seq[15:8]);
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      case (fill)
        FILL_EXTREME: b = i[0] ? 8'hFF : 8'h00;
        FILL_FRAMING: begin
          case ($urandom_range(0, 3))
            0:       b = CH_STX;
            1:       b = CH_ETX;
            2:       b = CH_SUBST;
            default: b = 8'($urandom);
          endcase
        end
        default: b = 8'($urandom);
      endcase
      body.push_back(b);
    end
    repeat (PAD_LEN) body.push_back(8'($urandom));
    crc = '0;
    foreach (body[i]) crc = crc_ccitt(crc, body[i]);
    if (fault == FAULT_CRC) crc = crc ^ (16'd1 << $urandom_range(0, 15));
    body.push_back(crc[7:0]);
    body.push_back(crc[15:8]);
    if (fault == FAULT_SHORT || fault == FAULT_OPEN) begin
      n = $urandom_range(0, PKT_LEN - 1);
      while (body.size() > n) void'(body.pop_back());
    end
    if (fault == FAULT_LONG) repeat ($urandom_range(1, 6)) body.push_back(8'($urandom));

    send_link_byte(CH_STX, 1'($urandom));
    foreach (body[i]) begin
      // Escape the framing bytes that must be, plus now and then any other byte.
      if (body[i] == CH_ETX || body[i] == CH_SUBST || $urandom_range(0, 19) == 0) begin
        send_link_byte(CH_SUBST, 1'($urandom));
      end
      send_link_byte(body[i], 1'($urandom));
    end
    // An open frame leaves the block inside a packet: the next STX lands as data.
    if (fault != FAULT_OPEN) send_link_byte(CH_ETX, good);
  endtask

  // Line noise outside a packet; anything but STX is skipped.
  task automatic send_noise(input int count);
    logic [7:0] b;
    repeat (count) begin
      b = 8'($urandom);
      if (b == CH_STX) b = CH_ETX;
      send_link_byte(b, 1'($urandom));
    end
  endtask

  // Hold until every expected beat is out and the CRC shifter is quiet.
  task automatic settle;
    @(negedge clk) s_tvalid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
    if (idx == REG_NODE_ADDR) cur_addr = val[7:0];
    else if (idx == REG_APP_START) cur_app_start = val;
  endtask

  // Reprogram both registers with the block idle, and poke an unused index.
  task automatic configure(input logic [7:0] addr, input logic [15:0] start_word);
    settle();
    write_reg(REG_NODE_ADDR, addr);
    write_reg(REG_APP_START, start_word);
    write_reg(8'($urandom_range(2, 255)), 16'($urandom));
  endtask

  // Mostly well-formed packets with random content; the rest noise and damage.
  task automatic random_frame;
    int          r;
    logic [7:0]  cmd;
    logic [15:0] param;
    fault_e      fault;
    fill_e       fill;
    int          seq_off;
    calm = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 99) < 8) begin
      send_noise($urandom_range(1, 12));
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 76) fault = FAULT_NONE;
    else if (r < 80) fault = FAULT_CRC;
    else if (r < 84) fault = FAULT_TYPE;
    else if (r < 88) fault = FAULT_ADDR;
    else if (r < 94) fault = FAULT_SHORT;
    else if (r < 97) fault = FAULT_LONG;
    else fault = FAULT_OPEN;
    r = $urandom_range(0, 99);
    if (r < 22) cmd = CMD_WREN;
    else if (r < 47) cmd = CMD_FLASH;
    else if (r < 67) cmd = CMD_EEPROM;
    else if (r < 75) cmd = CMD_CHECK;
    else if (r < 79) cmd = CMD_QUERY;
    else if (r < 83) cmd = CMD_EXEC;
    else if (r < 87) cmd = CMD_RESET;
    else cmd = 8'($urandom);
    if (cmd == CMD_FLASH && $urandom_range(0, 4) != 0)
      param = 16'($urandom_range(16'hFFFF, cur_app_start));
    else
      param = 16'($urandom);
    seq_off = ($urandom_range(0, 99) < 85) ? 0 : $urandom_range(1, 65535);
    r = $urandom_range(0, 99);
    if (r < 75) fill = FILL_RANDOM;
    else if (r < 90) fill = FILL_FRAMING;
    else fill = FILL_EXTREME;
    send_packet(cmd, param, seq_off, fill, fault, 1'($urandom));
  endtask

  // Result side: random stalls and runs, plus one long hold once 100 beats have gone out.
  initial begin : result_sink
    int stall;
    int run;
    bit held;
    m_tready = 1'b0;
    held     = 1'b0;
    wait (!rst);
    forever begin
      if (!held && out_beats >= 100) begin
        held = 1'b1;
        @(negedge clk) m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          @(negedge clk) m_tready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
        end
        @(negedge clk) m_tready <= 1'b1;
        run = $urandom_range(1, 24);
        repeat (run - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_beats <= 0;
    else if (m_tvalid && m_tready) out_beats <= out_beats + 1;
  end

  // Watchdog: end the run if no channel moves a beat for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 < WATCHDOG_LIMIT) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("bootloader_packet_receiver_top verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    calm          = 1'b0;
    idle_cycles   = 0;
    cur_addr      = 8'd31;     // register values out of reset
    cur_app_start = 16'd2048;
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: reset register values first.
    send_noise(6);
    send_packet(CMD_FLASH, 16'h0800, 0, FILL_RANDOM, FAULT_NONE, 1'b0);   // no write enable
    send_packet(CMD_CHECK, 16'h0000, 0, FILL_RANDOM, FAULT_NONE, 1'b1);   // app good
    send_packet(CMD_CHECK, 16'hFFFF, 0, FILL_RANDOM, FAULT_NONE, 1'b0);   // app bad
    send_packet(CMD_WREN, 16'h1234, 0, FILL_RANDOM, FAULT_NONE, 1'b0);
    calm = 1'b1;
    send_packet(CMD_FLASH, 16'h0800, 0, FILL_EXTREME, FAULT_NONE, 1'b0);  // at the boundary
    calm = 1'b0;
    send_packet(CMD_FLASH, 16'h07FF, 0, FILL_RANDOM, FAULT_NONE, 1'b0);   // below app start
    send_packet(CMD_EEPROM, 16'hFFFF, 0, FILL_FRAMING, FAULT_NONE, 1'b0); // escaped payload
    send_packet(CMD_EEPROM, 16'h0010, 3, FILL_RANDOM, FAULT_NONE, 1'b0);  // seq ahead of the expected one
    send_packet(CMD_EXEC, 16'h0000, 0, FILL_RANDOM, FAULT_NONE, 1'b0);
    send_packet(CMD_RESET, 16'h0000, 0, FILL_RANDOM, FAULT_NONE, 1'b0);
    send_packet(8'h77, 16'h0000, 0, FILL_RANDOM, FAULT_NONE, 1'b0);       // unknown command
    send_link_byte(CH_STX, 1'b0);                                         // empty packet
    send_link_byte(CH_ETX, 1'b0);
    send_packet(CMD_WREN, 16'h0000, 0, FILL_RANDOM, FAULT_SHORT, 1'b0);
    send_packet(CMD_WREN, 16'h0000, 0, FILL_RANDOM, FAULT_LONG, 1'b0);
    send_packet(CMD_WREN, 16'h0000, 0, FILL_RANDOM, FAULT_CRC, 1'b0);
    send_packet(CMD_WREN, 16'h0000, 0, FILL_RANDOM, FAULT_TYPE, 1'b0);
    send_packet(CMD_WREN, 16'h0000, 0, FILL_RANDOM, FAULT_ADDR, 1'b0);
    send_packet(CMD_QUERY, 16'h0000, 0, FILL_RANDOM, FAULT_NONE, 1'b0);
    send_packet(CMD_FLASH, 16'hFFFF, 0, FILL_RANDOM, FAULT_NONE, 1'b0);   // write enable gone

    // Lowest register settings.
    configure(8'h00, 16'h0000);
    send_packet(CMD_WREN, 16'h0000, 0, FILL_RANDOM, FAULT_NONE, 1'b0);
    send_packet(CMD_FLASH, 16'h0000, 0, FILL_RANDOM, FAULT_NONE, 1'b0);

    // Highest register settings.
    configure(8'hFF, 16'hFFFF);
    send_packet(CMD_WREN, 16'h0000, 0, FILL_RANDOM, FAULT_NONE, 1'b0);
    send_packet(CMD_FLASH, 16'hFFFF, 0, FILL_EXTREME, FAULT_NONE, 1'b0);
    send_packet(CMD_FLASH, 16'hFFFE, 0, FILL_RANDOM, FAULT_NONE, 1'b0);

    // Random phases, each under its own register setting.
    repeat (3) begin
      configure(8'($urandom),
                ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 4095))
                                             : 16'($urandom));
      repeat (18) random_frame();
    end

    settle();
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("bootloader_packet_receiver_top verification clean");
    end else begin
      $display("bootloader_packet_receiver_top verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/bprx_pkg.sv
hw/rtl/bootloader_packet_receiver_top.sv
hw/rtl/bprx_checker.sv
sim/bootloader_packet_receiver_checker.sv
sim/bootloader_packet_receiver_top_tb.sv
